>>> sv/sbm_pkg.sv
// Shared types and constants of the spectrum bar meter.
// Holds the command codes, port structs, controller/datapath handshake structs
// and the fixed band edge table. Depends on nothing.
`timescale 1ns / 1ps

package sbm_pkg;

  localparam int BANDS       = 16;
  localparam int BAND_W      = 4;
  localparam int GROUP_W     = 2;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 12;
  localparam int GAIN_W      = 10;
  localparam int SLEW_W      = 12;
  localparam int SAMPLE_W    = 16;
  localparam int PEAK_W      = 8;
  localparam int COUNT_W     = 9;

  localparam logic [GAIN_W-1:0]  GAIN_RESET = 10'd256;
  localparam logic [SLEW_W-1:0]  SLEW_RESET = 12'd205;
  localparam logic [COUNT_W-1:0] LAST_INDEX = 9'd255;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLEW = 4'd1;

  localparam logic [PEAK_W-1:0] BAND_EDGE [BANDS+1] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd10, 8'd14, 8'd20, 8'd28,
    8'd40, 8'd54, 8'd74, 8'd101, 8'd137, 8'd187, 8'd255
  };

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_FRAME_END = 2'd1,
    CMD_RENDER    = 2'd2,
    CMD_RESTART   = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  column_base;
    logic [13:0] height_a;
    logic [13:0] height_b;
    logic [13:0] height_c;
    logic [13:0] height_d;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sample_upd;
    logic shown_clr;
    logic frame_begin;
    logic log_start;
    logic height_store;
    logic render_begin;
    logic render_issue;
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic log_done;
    logic band_last;
    logic quad_last;
  } dp_status_t;

  // Band that a sample index below the last edge falls into.
  function automatic logic [BAND_W-1:0] band_of(input logic [PEAK_W-1:0] idx);
    logic [BAND_W-1:0] b;
    b = '0;
    for (int i = 0; i < BANDS; i++) begin
      if (idx >= BAND_EDGE[i] && idx < BAND_EDGE[i+1]) begin
        b = BAND_W'(i);
      end
    end
    return b;
  endfunction

endpackage

>>> sv/sbm_log_unit.sv
// Iterative log2 unit: one squaring of the normalized mantissa per cycle.
// Gives log256 of an 8-bit peak in Q0.FRAC_BITS, rounded half up.
// Stand-alone; uses no package.
`timescale 1ns / 1ps

module sbm_log_unit #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [7:0]         peak,
  output logic               done,
  output logic [FRAC_BITS:0] value
);

  localparam int SH    = 19 - FRAC_BITS;
  localparam int LOG_W = FRAC_BITS + 1;
  localparam logic [19:0] HALF = 20'(1) << (SH - 1);

  logic [31:0] mant;
  logic [2:0]  expo;
  logic [15:0] frac;
  logic [3:0]  bits_left;
  logic        running;
  logic        rounding;
  logic [2:0]  lead;
  logic [31:0] mant_init;
  logic [63:0] square;
  logic [19:0] rounded;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 8; i++) begin
      if (peak[i]) begin
        lead = 3'(i);
      end
    end
  end

  assign mant_init = {peak, 24'd0} << (3'd7 - lead);
  assign square    = 64'(mant) * 64'(mant);
  assign rounded   = {1'b0, expo, frac} + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      rounding <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        rounding <= 1'b0;
      end else if (running) begin
        if (bits_left == 4'd0) begin
          running  <= 1'b0;
          rounding <= 1'b1;
        end
      end else if (rounding) begin
        rounding <= 1'b0;
        done     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mant      <= mant_init;
      expo      <= lead;
      frac      <= '0;
      bits_left <= 4'd15;
    end else if (running) begin
      // A square of 2.0 or more yields a one bit and renormalizes.
      frac      <= {frac[14:0], square[63]};
      mant      <= square[63] ? square[63:32] : square[62:31];
      bits_left <= bits_left - 4'd1;
    end else if (rounding) begin
      value <= rounded[SH +: LOG_W];
    end
  end

endmodule

>>> sv/sbm_datapath.sv
// Datapath of the spectrum bar meter: band peaks, target and shown height
// memories, height scaling, slew lanes and the result register.
// Depends on sbm_pkg and sbm_log_unit.
`timescale 1ns / 1ps

module sbm_datapath
  import sbm_pkg::*;
#(
  parameter int HISTORY_ROWS = 16,
  parameter int FRAC_BITS    = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_ctl_t                    ctl,
  output dp_status_t                 status,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       cfg_valid,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                       result_valid,
  output result_t                    result
);

  localparam int HW     = FRAC_BITS + 2;
  localparam int LOG_W  = FRAC_BITS + 1;
  localparam int ROW_W  = (HISTORY_ROWS > 1) ? $clog2(HISTORY_ROWS) : 1;
  localparam int ADDR_W = ROW_W + GROUP_W;
  localparam int DEPTH  = HISTORY_ROWS * 4;
  localparam int WORD_W = 4 * HW;
  localparam logic [HW-1:0]     HEIGHT_MAX = '1;
  localparam logic [ROW_W:0]    ROWS       = (ROW_W + 1)'(HISTORY_ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(HISTORY_ROWS - 1);
  localparam logic [ADDR_W-1:0] QUAD_LAST  = ADDR_W'(DEPTH - 1);

  logic [GAIN_W-1:0]  gain;
  logic [SLEW_W-1:0]  slew;
  logic [COUNT_W-1:0] sample_index;
  logic [PEAK_W-1:0]  band_peak [BANDS];
  logic [ROW_W-1:0]   row_ptr;
  logic [BAND_W-1:0]  band_cnt;
  logic [3*HW-1:0]    quad_acc;
  logic [ADDR_W-1:0]  quad_cnt;
  logic [HISTORY_ROWS-1:0] tgt_row_ok;
  logic [HISTORY_ROWS-1:0] shw_row_ok;

  logic [WORD_W-1:0] tgt_mem [DEPTH];
  logic [WORD_W-1:0] shw_mem [DEPTH];

  logic               rd_v;
  logic [ROW_W-1:0]   rd_row;
  logic [GROUP_W-1:0] rd_g;
  logic               rd_tgt_ok;
  logic               rd_shw_ok;
  logic [WORD_W-1:0]  tgt_q;
  logic [WORD_W-1:0]  shw_q;

  logic [BAND_W-1:0]   sample_band;
  logic [PEAK_W-1:0]   sample_val;
  logic                sample_hit;
  logic [ROW_W-1:0]    ptr_dec;
  logic [ROW_W:0]      row_sum;
  logic [ROW_W-1:0]    tgt_row;
  logic                log_done;
  logic [LOG_W-1:0]    log_value;
  logic [LOG_W+10:0]   h_prod;
  logic [HW+1:0]       h_scaled;
  logic [HW-1:0]       height;
  logic                tgt_write;
  logic [FRAC_BITS-1:0] step;
  logic [HW-1:0]       step_h;
  logic [WORD_W-1:0]   new_quad;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
      slew <= SLEW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN: gain <= cfg_data[GAIN_W-1:0];
        REG_SLEW: slew <= cfg_data[SLEW_W-1:0];
        default:  ;
      endcase
    end
  end

  // Sample binning.
  assign sample_band = band_of(sample_index[PEAK_W-1:0]);
  assign sample_val  = sample[14:7];
  assign sample_hit  = ctl.sample_upd && (sample_index < LAST_INDEX) && !sample[15];

  assign ptr_dec = (row_ptr == '0) ? ROW_LAST : row_ptr - ROW_W'(1);

  // Target row of history age r is the ring slot row_ptr + r.
  assign row_sum = {1'b0, row_ptr} + {1'b0, quad_cnt[ADDR_W-1:GROUP_W]};
  assign tgt_row = (row_sum >= ROWS) ? ROW_W'(row_sum - ROWS) : row_sum[ROW_W-1:0];

  sbm_log_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_log (
    .clk  (clk),
    .rst  (rst),
    .start(ctl.log_start),
    .peak (band_peak[band_cnt]),
    .done (log_done),
    .value(log_value)
  );

  // Height = (log * gain + 0.5) in Q2.8 gain scale, saturated.
  assign h_prod   = (LOG_W + 11)'(log_value) * (LOG_W + 11)'(gain) + (LOG_W + 11)'(128);
  assign h_scaled = h_prod[LOG_W+10:8];
  assign height   = (h_scaled > (HW + 2)'(HEIGHT_MAX)) ? HEIGHT_MAX : h_scaled[HW-1:0];
  assign tgt_write = ctl.height_store && (band_cnt[1:0] == 2'd3);

  generate
    if (FRAC_BITS >= 12) begin : g_step_up
      assign step = FRAC_BITS'(slew) << (FRAC_BITS - 12);
    end else begin : g_step_dn
      assign step = FRAC_BITS'(slew >> (12 - FRAC_BITS));
    end
  endgenerate
  assign step_h = HW'(step);

  function automatic logic [HW-1:0] slew_one(input logic [HW-1:0] s,
                                             input logic [HW-1:0] t,
                                             input logic [HW-1:0] st);
    logic [HW-1:0] r;
    r = s;
    if (s < t && (t - s) > st) begin
      r = s + st;
    end else if (s > t && (s - t) > st) begin
      r = s - st;
    end
    return r;
  endfunction

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      new_quad[j*HW +: HW] = slew_one(rd_shw_ok ? shw_q[j*HW +: HW] : '0,
                                      rd_tgt_ok ? tgt_q[j*HW +: HW] : '0,
                                      step_h);
    end
  end

  assign status.log_done  = log_done;
  assign status.band_last = (band_cnt == BAND_W'(BANDS - 1));
  assign status.quad_last = (quad_cnt == QUAD_LAST);

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      row_ptr      <= '0;
      band_cnt     <= '0;
      quad_cnt     <= '0;
      tgt_row_ok   <= '0;
      shw_row_ok   <= '0;
      rd_v         <= 1'b0;
      result_valid <= 1'b0;
      for (int b = 0; b < BANDS; b++) begin
        band_peak[b] <= '0;
      end
    end else begin
      if (ctl.sample_upd) begin
        if (sample_hit && sample_val > band_peak[sample_band]) begin
          band_peak[sample_band] <= sample_val;
        end
        if (!sample_index[COUNT_W-1]) begin
          sample_index <= sample_index + COUNT_W'(1);
        end
      end
      if (ctl.frame_begin) begin
        row_ptr  <= ptr_dec;
        band_cnt <= '0;
      end
      if (ctl.height_store) begin
        band_peak[band_cnt] <= '0;
        band_cnt            <= band_cnt + BAND_W'(1);
        if (status.band_last) begin
          tgt_row_ok[row_ptr] <= 1'b1;
          sample_index        <= '0;
        end
      end
      if (ctl.render_begin) begin
        quad_cnt <= '0;
      end else if (ctl.render_issue) begin
        quad_cnt <= quad_cnt + ADDR_W'(1);
      end
      // A shown row becomes valid once its last quad has been written.
      if (rd_v && rd_g == 2'd3) begin
        shw_row_ok[rd_row] <= 1'b1;
      end
      if (ctl.shown_clr) begin
        shw_row_ok <= '0;
      end
      rd_v         <= ctl.render_issue;
      result_valid <= rd_v;
    end
  end

  // Heights of a row gather four at a time before one memory write.
  always_ff @(posedge clk) begin
    if (ctl.height_store) begin
      quad_acc <= {height, quad_acc[3*HW-1:HW]};
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_write) begin
      tgt_mem[{row_ptr, band_cnt[3:2]}] <= {height, quad_acc};
    end
    if (ctl.render_issue) begin
      tgt_q <= tgt_mem[{tgt_row, quad_cnt[GROUP_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      shw_mem[{rd_row, rd_g}] <= new_quad;
    end
    if (ctl.render_issue) begin
      shw_q <= shw_mem[quad_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.render_issue) begin
      rd_row    <= quad_cnt[ADDR_W-1:GROUP_W];
      rd_g      <= quad_cnt[GROUP_W-1:0];
      rd_tgt_ok <= tgt_row_ok[tgt_row];
      rd_shw_ok <= shw_row_ok[quad_cnt[ADDR_W-1:GROUP_W]];
    end
    if (rd_v) begin
      result.row         <= 4'(rd_row);
      result.column_base <= {rd_g, 2'b00};
      result.height_a    <= 14'(new_quad[0*HW +: HW]);
      result.height_b    <= 14'(new_quad[1*HW +: HW]);
      result.height_c    <= 14'(new_quad[2*HW +: HW]);
      result.height_d    <= 14'(new_quad[3*HW +: HW]);
      result.last        <= (rd_row == ROW_LAST) && (rd_g == 2'd3);
    end
  end

  a_store_needs_log: assert property (@(posedge clk) disable iff (rst)
    ctl.height_store |-> log_done)
    else $error("height stored without a finished log value");

  a_launch_quiet: assert property (@(posedge clk) disable iff (rst)
    ctl.log_start |-> !log_done)
    else $error("log launched while a previous result was pending");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("result strobe continued past the final result");

endmodule

>>> sv/sbm_ctrl.sv
// Controller of the spectrum bar meter: accepts commands and sequences the
// frame-end band loop and the render sweep. Depends on sbm_pkg.
`timescale 1ns / 1ps

module sbm_ctrl
  import sbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  output logic       busy,
  output dp_ctl_t    ctl,
  input  dp_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_FRAME_LOG  = 5'b00010,
    S_FRAME_WAIT = 5'b00100,
    S_RENDER     = 5'b01000,
    S_DRAIN      = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_SAMPLE: ctl.sample_upd = 1'b1;
            CMD_RESTART: ctl.shown_clr = 1'b1;
            CMD_FRAME_END: begin
              ctl.frame_begin = 1'b1;
              state_next      = S_FRAME_LOG;
            end
            CMD_RENDER: begin
              ctl.render_begin = 1'b1;
              state_next       = S_RENDER;
            end
            default: ;
          endcase
        end
      end
      S_FRAME_LOG: begin
        ctl.log_start = 1'b1;
        state_next    = S_FRAME_WAIT;
      end
      S_FRAME_WAIT: begin
        if (status.log_done) begin
          ctl.height_store = 1'b1;
          state_next       = status.band_last ? S_IDLE : S_FRAME_LOG;
        end
      end
      S_RENDER: begin
        ctl.render_issue = 1'b1;
        if (status.quad_last) begin
          state_next = S_DRAIN;
        end
      end
      // The last shown quad is written back at the end of this cycle.
      S_DRAIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/spectrum_bar_meter_unit.sv
// Top level of the spectrum bar meter: controller plus datapath.
// Depends on sbm_pkg, sbm_ctrl and sbm_datapath.
`timescale 1ns / 1ps
//
// Usage:
//   An item is taken at a rising edge with start high and busy low; item.cmd
//   selects sample, end of frame, render tick or restart.
//   A sample or a restart leaves busy low.
//   End of frame runs the iterative log unit once per band, for all 16
//   bands; each run makes 16 squarings.
//   A render tick sweeps 4*HISTORY_ROWS quads, one per cycle through the
//   shown-height memory port; busy is high for the sweep and the drain state;
//   results come from the memory read registers via the result register.
//   Each result is shown for one cycle with result_valid high; result.last
//   marks the final one. The receiver has no way to stall the results.
//   Configuration writes use cfg_valid/cfg_ready (always ready): index 0 is
//   gain, index 1 is slew_step; other indexes are ignored.
//   Reset clears peaks, counters, history and shown heights (via row valid
//   bits) and loads the default gain and slew step; no clearing pass is run.

module spectrum_bar_meter_unit
  import sbm_pkg::*;
#(
  parameter int HISTORY_ROWS = 16,
  parameter int FRAC_BITS    = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output logic                   result_valid,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_ctl_t    ctl;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sbm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (item.cmd),
    .busy  (busy),
    .ctl   (ctl),
    .status(status)
  );

  sbm_datapath #(
    .HISTORY_ROWS(HISTORY_ROWS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .status      (status),
    .sample      (item.sample),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

>>> verif/tb_spectrum_bar_meter_unit.sv
// Self-checking testbench for spectrum_bar_meter_unit: directed table, then random phases.
// Predicts every render result from its own model of the band peaks, history and slew.
// Depends on sbm_pkg and spectrum_bar_meter_unit.
`timescale 1ns / 1ps

module tb_spectrum_bar_meter_unit;
  import sbm_pkg::*;

  localparam int ROWS          = 16;
  localparam int FRAC_BITS     = 12;
  localparam int CELLS         = ROWS * BANDS;
  localparam int HEIGHT_MAX    = (1 << (FRAC_BITS + 2)) - 1;
  localparam int LOG_SHIFT     = 19 - FRAC_BITS;
  localparam int PREDICTED     = -1;
  localparam int SETTLE_CYCLES = 340;
  localparam int PHASE_ITEMS   = 36;
  localparam int REPORT_LINES  = 100;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  item_t                  item = '0;
  logic                   result_valid;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  spectrum_bar_meter_unit #(
    .HISTORY_ROWS(ROWS),
    .FRAC_BITS   (FRAC_BITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted meter state.
  logic [COUNT_W-1:0] frame_pos;
  logic [PEAK_W-1:0]  peak_m [BANDS];
  logic [13:0]        target_m [CELLS];
  logic [13:0]        shown_m [CELLS];
  int unsigned        newest_m;
  logic [GAIN_W-1:0]  gain_m;
  logic [SLEW_W-1:0]  slew_m;

  result_t expected_bars [$];
  result_t want_bar;
  int      mismatches = 0;
  int      sent = 0;
  int      burst_left = 0;

  typedef struct {
    cmd_code_t   cmd;
    logic [15:0] smp;
    int          flat;  // height typed in for every bar of a render, or PREDICTED
  } step_row_t;

  step_row_t directed_steps [22] = '{
    '{CMD_RENDER,    16'h0000, 0},
    '{CMD_SAMPLE,    16'h8000, PREDICTED},
    '{CMD_SAMPLE,    16'h007F, PREDICTED},
    '{CMD_SAMPLE,    16'hFFFF, PREDICTED},
    '{CMD_FRAME_END, 16'h0000, PREDICTED},
    '{CMD_RENDER,    16'h0000, 0},
    '{CMD_SAMPLE,    16'h7FFF, PREDICTED},
    '{CMD_SAMPLE,    16'h0080, PREDICTED},
    '{CMD_SAMPLE,    16'h5555, PREDICTED},
    '{CMD_SAMPLE,    16'h2AAA, PREDICTED},
    '{CMD_SAMPLE,    16'h0000, PREDICTED},
    '{CMD_SAMPLE,    16'h4000, PREDICTED},
    '{CMD_FRAME_END, 16'hFFFF, PREDICTED},
    '{CMD_RENDER,    16'h0000, PREDICTED},
    '{CMD_RENDER,    16'hFFFF, PREDICTED},
    '{CMD_RESTART,   16'h0000, PREDICTED},
    '{CMD_RENDER,    16'h0000, PREDICTED},
    '{CMD_SAMPLE,    16'h7FFF, PREDICTED},
    '{CMD_FRAME_END, 16'h0000, PREDICTED},
    '{CMD_RENDER,    16'h0000, PREDICTED},
    '{CMD_RESTART,   16'hFFFF, PREDICTED},
    '{CMD_RENDER,    16'h0000, PREDICTED}
  };

  task automatic report_miss(input string what);
    mismatches++;
    // Keep the log readable when the design is badly off.
    if (mismatches <= REPORT_LINES) begin
      $display("%0t: mismatch: %s", $realtime, what);
    end
  endtask

  // log256 of a band peak in Q0.FRAC_BITS, via log2 by repeated squaring.
  function automatic int unsigned log256_q(input logic [PEAK_W-1:0] p);
    int unsigned e;
    int unsigned l;
    logic [63:0] x;
    if (p == 0) begin
      return 0;
    end
    e = 0;
    while ((p >> (e + 1)) != 0) begin
      e++;
    end
    x = 64'(p) << (31 - e);
    l = e << 16;
    for (int k = 16; k > 0; k--) begin
      x = (x * x) >> 31;
      if (x >= 64'h1_0000_0000) begin
        l = l | (32'd1 << (k - 1));
        x = x >> 1;
      end
    end
    return (l + (32'd1 << (LOG_SHIFT - 1))) >> LOG_SHIFT;
  endfunction

  // Advances the predicted meter by one accepted command and queues its bars.
  function automatic void advance_meter(input item_t it, input int flat);
    int unsigned v, h, step, s, t, base, c;
    result_t bar;
    case (cmd_code_t'(it.cmd))
      CMD_SAMPLE: begin
        if (frame_pos < LAST_INDEX && !it.sample[15]) begin
          v = it.sample[14:7];
          for (int b = 0; b < BANDS; b++) begin
            if (frame_pos >= BAND_EDGE[b] && frame_pos < BAND_EDGE[b+1] && v > peak_m[b]) begin
              peak_m[b] = PEAK_W'(v);
            end
          end
        end
        if (frame_pos < 9'd256) begin
          frame_pos++;
        end
      end
      CMD_FRAME_END: begin
        newest_m = (newest_m + ROWS - 1) % ROWS;
        base = newest_m * BANDS;
        for (int b = 0; b < BANDS; b++) begin
          h = (log256_q(peak_m[b]) * gain_m + 128) >> 8;
          if (h > HEIGHT_MAX) begin
            h = HEIGHT_MAX;
          end
          target_m[base + b] = 14'(h);
          peak_m[b] = '0;
        end
        frame_pos = '0;
      end
      CMD_RESTART: begin
        foreach (shown_m[i]) begin
          shown_m[i] = '0;
        end
      end
      default: begin
        step = 32'(slew_m);
        step = (FRAC_BITS >= 12) ? (step << (FRAC_BITS - 12)) : (step >> (12 - FRAC_BITS));
        for (int r = 0; r < ROWS; r++) begin
          base = ((newest_m + r) % ROWS) * BANDS;
          for (int b = 0; b < BANDS; b++) begin
            s = shown_m[r * BANDS + b];
            t = target_m[base + b];
            // Heights only move when the gap is wider than one step.
            if (s < t && t - s > step) begin
              s = s + step;
            end else if (s > t && s - t > step) begin
              s = s - step;
            end
            shown_m[r * BANDS + b] = 14'(s);
          end
        end
        for (int r = 0; r < ROWS; r++) begin
          for (int b = 0; b < BANDS; b += 4) begin
            c = r * BANDS + b;
            bar.row = 4'(r);
            bar.column_base = 4'(b);
            if (flat >= 0) begin
              bar.height_a = 14'(flat);
              bar.height_b = 14'(flat);
              bar.height_c = 14'(flat);
              bar.height_d = 14'(flat);
            end else begin
              bar.height_a = shown_m[c];
              bar.height_b = shown_m[c + 1];
              bar.height_c = shown_m[c + 2];
              bar.height_d = shown_m[c + 3];
            end
            bar.last = (r == ROWS - 1) && (b + 4 >= BANDS);
            expected_bars.push_back(bar);
          end
        end
      end
    endcase
  endfunction

  // Called just after a rising edge; returns at the edge where the transfer happens.
  task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] smp, input int flat);
    item_t it;
    it.cmd = cmd;
    it.sample = smp;
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    advance_meter(it, flat);
    sent++;
  endtask

  // Bursts of back-to-back commands separated by random gaps.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Waits until every bar has arrived and any frame-end log pass has finished.
  task automatic settle();
    start <= 1'b0;
    while (expected_bars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx == REG_GAIN) begin
      gain_m = data[GAIN_W-1:0];
    end else if (idx == REG_SLEW) begin
      slew_m = data[SLEW_W-1:0];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_bars.size() == 0) begin
        report_miss("bar result with nothing expected");
      end else begin
        want_bar = expected_bars.pop_front();
        if (result.row !== want_bar.row)
          report_miss($sformatf("row %0d, expected %0d", result.row, want_bar.row));
        if (result.column_base !== want_bar.column_base)
          report_miss($sformatf("column_base %0d, expected %0d",
                                result.column_base, want_bar.column_base));
        if (result.height_a !== want_bar.height_a)
          report_miss($sformatf("row %0d col %0d height_a %0d, expected %0d", want_bar.row,
                                want_bar.column_base, result.height_a, want_bar.height_a));
        if (result.height_b !== want_bar.height_b)
          report_miss($sformatf("row %0d col %0d height_b %0d, expected %0d", want_bar.row,
                                want_bar.column_base, result.height_b, want_bar.height_b));
        if (result.height_c !== want_bar.height_c)
          report_miss($sformatf("row %0d col %0d height_c %0d, expected %0d", want_bar.row,
                                want_bar.column_base, result.height_c, want_bar.height_c));
        if (result.height_d !== want_bar.height_d)
          report_miss($sformatf("row %0d col %0d height_d %0d, expected %0d", want_bar.row,
                                want_bar.column_base, result.height_d, want_bar.height_d));
        if (result.last !== want_bar.last)
          report_miss($sformatf("row %0d col %0d last %b, expected %b", want_bar.row,
                                want_bar.column_base, result.last, want_bar.last));
      end
    end
  end

  initial begin
    logic [GAIN_W-1:0] gain_set [6];
    logic [SLEW_W-1:0] slew_set [6];
    logic [15:0]       smp;
    int                phase_end;
    int                choice;
    int                n;
    bit                long_done;

    gain_set = '{GAIN_RESET, 10'd1023, 10'd0, 10'd1023, 10'd1, 10'($urandom_range(0, 1023))};
    slew_set = '{SLEW_RESET, 12'd4095, 12'd0, 12'd0, 12'd1, 12'($urandom_range(0, 4095))};
    long_done = 1'b0;
    frame_pos = '0;
    newest_m = 0;
    gain_m = GAIN_RESET;
    slew_m = SLEW_RESET;
    foreach (peak_m[i]) peak_m[i] = '0;
    foreach (target_m[i]) target_m[i] = '0;
    foreach (shown_m[i]) shown_m[i] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      send_cmd(directed_steps[i].cmd, directed_steps[i].smp, directed_steps[i].flat);
      pace();
    end

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      if (phase > 0) begin
        write_reg(REG_GAIN, CFG_DATA_W'(gain_set[phase]));
        write_reg(REG_SLEW, slew_set[phase]);
        // An unmapped index must leave both registers alone.
        write_reg(CFG_INDEX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
      end
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        choice = $urandom_range(0, 99);
        if (choice < 65) begin
          // One long frame nears or runs past the last band edge and the index limit.
          if (phase == 1 && !long_done) begin
            n = $urandom_range(250, 262);
            long_done = 1'b1;
          end else begin
            n = $urandom_range(0, 24);
          end
          repeat (n) begin
            case ($urandom_range(0, 7))
              0: smp = 16'h7FFF;
              1: smp = 16'h8000 | 16'($urandom_range(0, 32767));
              2: smp = 16'($urandom_range(0, 127));
              3: smp = 16'($urandom);
              default: smp = 16'($urandom_range(128, 32767));
            endcase
            send_cmd(CMD_SAMPLE, smp, PREDICTED);
            pace();
          end
          send_cmd(CMD_FRAME_END, 16'($urandom), PREDICTED);
          pace();
          if ($urandom_range(0, 1) == 1) begin
            send_cmd(CMD_RENDER, 16'($urandom), PREDICTED);
            pace();
          end
        end else if (choice < 78) begin
          send_cmd(CMD_RENDER, 16'($urandom), PREDICTED);
          pace();
        end else if (choice < 86) begin
          send_cmd(CMD_RESTART, 16'($urandom), PREDICTED);
          pace();
        end else begin
          send_cmd(2'($urandom_range(0, 3)), 16'($urandom), PREDICTED);
          pace();
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("spectrum_bar_meter_unit verification clean");
    end else begin
      $display("spectrum_bar_meter_unit verification failed");
    end
    $finish;
  end

  // Roughly six times the slowest legal run.
  initial begin
    #(1_000_000 * 20);
    $display("spectrum_bar_meter_unit verification failed");
    $finish;
  end

endmodule
